// File: rtl/wsfr_pkg.sv
// ----------------------------------------------------------------------------
// wsfr_pkg
// Shared types and constants of the WebSocket frame receiver.
// ----------------------------------------------------------------------------
package wsfr_pkg;

  localparam int LEN_W       = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int KEY_BYTES   = 4;
  localparam int KEY_IDX_W   = $clog2(KEY_BYTES);

  localparam logic [LEN_W-1:0] LIMIT_RESET = 7'd64;
  localparam logic [3:0]       OP_TEXT     = 4'h1;
  localparam logic [3:0]       OP_CLOSE    = 4'h8;
  localparam logic [0:0]       REG_LIMIT   = 1'b0;

  typedef enum logic [3:0] {
    PH_HDR1 = 4'b0001,
    PH_HDR2 = 4'b0010,
    PH_MASK = 4'b0100,
    PH_DATA = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    V_TEXT   = 3'd0,
    V_CLOSE  = 3'd1,
    V_FRAG   = 3'd2,
    V_LONG   = 3'd3,
    V_OPCODE = 3'd4
  } verdict_t;

  // one classified word, front to back
  typedef struct packed {
    logic                 load_key;
    logic [KEY_IDX_W-1:0] key_slot;
    logic                 masked;
    logic [7:0]           byte_val;
    logic                 data_valid;
    logic [LEN_W-1:0]     data_index;
    logic                 frame_end;
    verdict_t             verdict;
    logic [3:0]           opcode;
  } item_t;

endpackage

// File: rtl/wsfr_front.sv
// ----------------------------------------------------------------------------
// wsfr_front
// Header parser: tracks the frame phase and classifies each received byte.
// ----------------------------------------------------------------------------
module wsfr_front
  import wsfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             restart,
  input  logic [LEN_W-1:0] length_limit,
  input  logic             queue_full,
  output logic             push,
  output item_t            item
);

  phase_t               phase, phase_next, ph;
  logic [3:0]           opcode_held, opcode_held_next;
  logic                 final_flag, final_flag_next;
  logic                 masked_flag, masked_flag_next;
  logic [LEN_W-1:0]     payload_length, payload_length_next;
  logic [LEN_W-1:0]     byte_count, byte_count_next, count_inc;
  logic [KEY_IDX_W-1:0] mask_cnt, mask_cnt_next;
  verdict_t             judged;

  assign in_ready  = !queue_full;
  assign push      = in_valid && in_ready;
  assign count_inc = byte_count + LEN_W'(1);

  always_comb begin
    if (!final_flag) judged = V_FRAG;
    else if (opcode_held == OP_TEXT) judged = V_TEXT;
    else if (opcode_held == OP_CLOSE) judged = V_CLOSE;
    else judged = V_OPCODE;
  end

  always_comb begin
    ph                  = restart ? PH_HDR1 : phase;
    phase_next          = ph;
    opcode_held_next    = opcode_held;
    final_flag_next     = final_flag;
    masked_flag_next    = masked_flag;
    payload_length_next = payload_length;
    byte_count_next     = byte_count;
    mask_cnt_next       = mask_cnt;
    item                = '0;
    item.byte_val       = in_byte;
    unique case (ph)
      PH_HDR1: begin
        opcode_held_next = in_byte[3:0];
        final_flag_next  = in_byte[7];
        byte_count_next  = '0;
        phase_next       = PH_HDR2;
      end
      PH_HDR2: begin
        payload_length_next = in_byte[6:0];
        masked_flag_next    = in_byte[7];
        byte_count_next     = '0;
        mask_cnt_next       = '0;
        if (in_byte[6:0] >= length_limit) begin
          item.frame_end = 1'b1;
          item.verdict   = V_LONG;
          phase_next     = PH_HDR1;
        end else if (in_byte[7]) begin
          phase_next = PH_MASK;
        end else if (in_byte[6:0] == '0) begin
          item.frame_end = 1'b1;
          item.verdict   = judged;
          phase_next     = PH_HDR1;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_MASK: begin
        item.load_key = 1'b1;
        item.key_slot = mask_cnt;
        if (mask_cnt == KEY_IDX_W'(KEY_BYTES - 1)) begin
          if (payload_length == '0) begin
            item.frame_end = 1'b1;
            item.verdict   = judged;
            phase_next     = PH_HDR1;
          end else begin
            phase_next = PH_DATA;
          end
        end else begin
          mask_cnt_next = mask_cnt + KEY_IDX_W'(1);
        end
      end
      PH_DATA: begin
        item.data_valid = 1'b1;
        item.data_index = byte_count;
        item.key_slot   = byte_count[KEY_IDX_W-1:0];
        item.masked     = masked_flag;
        byte_count_next = count_inc;
        if (count_inc >= payload_length) begin
          item.frame_end = 1'b1;
          item.verdict   = judged;
          phase_next     = PH_HDR1;
        end
      end
      default: begin
        phase_next = PH_HDR1;
      end
    endcase
    item.opcode = opcode_held_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HDR1;
      opcode_held    <= '0;
      final_flag     <= 1'b0;
      masked_flag    <= 1'b0;
      payload_length <= '0;
      byte_count     <= '0;
      mask_cnt       <= '0;
    end else if (push) begin
      phase          <= phase_next;
      opcode_held    <= opcode_held_next;
      final_flag     <= final_flag_next;
      masked_flag    <= masked_flag_next;
      payload_length <= payload_length_next;
      byte_count     <= byte_count_next;
      mask_cnt       <= mask_cnt_next;
    end
  end

endmodule

// File: rtl/wsfr_queue.sv
// ----------------------------------------------------------------------------
// wsfr_queue
// Short FIFO of classified words between parser and output stage.
// ----------------------------------------------------------------------------
module wsfr_queue
  import wsfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  pop_valid,
  output item_t pop_item
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = slots[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !pop_valid |-> !pop) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

// File: rtl/wsfr_back.sv
// ----------------------------------------------------------------------------
// wsfr_back
// Output stage: keeps the mask key, unmasks payload, holds the result word.
// ----------------------------------------------------------------------------
module wsfr_back
  import wsfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             data_valid,
  output logic [7:0]       data_byte,
  output logic [LEN_W-1:0] data_index,
  output logic             frame_end,
  output verdict_t         verdict,
  output logic [3:0]       frame_opcode
);

  logic [7:0] mask_key [KEY_BYTES];
  logic [7:0] unmasked;

  assign pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    unmasked = q_item.byte_val;
    if (q_item.masked) unmasked = q_item.byte_val ^ mask_key[q_item.key_slot];
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.load_key) mask_key[q_item.key_slot] <= q_item.byte_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_valid   <= q_item.data_valid;
      data_byte    <= q_item.data_valid ? unmasked : 8'h00;
      data_index   <= q_item.data_index;
      frame_end    <= q_item.frame_end;
      verdict      <= q_item.verdict;
      frame_opcode <= q_item.opcode;
    end
  end

endmodule

// File: rtl/websocket_frame_receiver.sv
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// Parses client WebSocket frames one byte per word; unmasks the payload and
// gives a verdict on the last word of each frame.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  s_*      in   tdata = in_byte, tuser = restart
//  m_*      out  tdata = data_byte, data_index, verdict, frame_opcode;
//                tuser = data_valid, tlast = frame_end
//  APB      in   reg 0 at 0x0: length_limit (7 bits, reset 64)
//
// One result word per input word; sustained rate is one word per cycle while
// m_tready is held high. Each word enters the two-entry queue, then the output
// register. The parser stalls only when the queue is full; the output stage
// drains the queue whenever its register is empty or being taken.
// Reset is synchronous and returns the parser to the first header byte.
// ----------------------------------------------------------------------------
module websocket_frame_receiver
  import wsfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tuser,   // [0] restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] data_byte, [14:8] data_index,
                                 // [17:15] verdict, [21:18] frame_opcode, 0
  output logic        m_tuser,   // [0] data_valid
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [LEN_W-1:0] length_limit;
  logic             cfg_write;
  logic             push, queue_full, pop, q_valid;
  item_t            push_item, q_item;
  logic [7:0]       data_byte;
  logic [LEN_W-1:0] data_index;
  verdict_t         verdict;
  logic [3:0]       frame_opcode;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == {REG_LIMIT, 2'b00}) ? {25'd0, length_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= LIMIT_RESET;
    end else if (cfg_write && paddr == {REG_LIMIT, 2'b00}) begin
      length_limit <= pwdata[LEN_W-1:0];
    end
  end

  wsfr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_byte      (s_tdata),
    .restart      (s_tuser),
    .length_limit (length_limit),
    .queue_full   (queue_full),
    .push         (push),
    .item         (push_item)
  );

  wsfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  wsfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .data_valid   (m_tuser),
    .data_byte    (data_byte),
    .data_index   (data_index),
    .frame_end    (m_tlast),
    .verdict      (verdict),
    .frame_opcode (frame_opcode)
  );

  assign m_tdata = {2'b00, frame_opcode, verdict, data_index, data_byte};

`ifndef NO_ASSERTIONS
  a_idle_data_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (data_byte == 8'h00) && (data_index == '0))
    else $error("data fields set on a non-data word");
  a_verdict_only_at_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> verdict == V_TEXT)
    else $error("verdict set before frame end");
  a_long_not_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && verdict == V_LONG |-> !m_tuser)
    else $error("too-long verdict on a payload word");
`endif

endmodule
